FILE: src/fhs_pkg.sv
// ----------------------------------------------------------------------------
// fhs_pkg: shared constants and types for the FNV-1a visited-state set
// Sizes of the entry store and slot table, hash constants, mode codes and
// the packed layouts of one stored entry and one result.
// ----------------------------------------------------------------------------
package fhs_pkg;

    localparam int ENTRIES   = 4096;
    localparam int ENT_BITS  = $clog2(ENTRIES);
    localparam int CNT_BITS  = ENT_BITS + 1;
    localparam int SLOT_BITS = 13;
    localparam int SLOTS     = 1 << SLOT_BITS;
    localparam int KEY_BYTES = 11;
    localparam int RND_BITS  = $clog2(KEY_BYTES + 1);
    localparam int KEY_W     = 88;

    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (8 * (11 - KEY_BYTES));

    localparam logic [31:0] FNV_START = 32'd2166136261;
    localparam logic [31:0] FNV_MUL   = 32'd16777619;

    localparam logic [12:0] LIMIT_RESET = 13'd4096;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_READ   = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

    typedef struct packed {
        logic [63:0]          key_low;
        logic [23:0]          key_high;
        logic [12:0]          parent;
        logic [7:0]           move_code;
        logic [SLOT_BITS-1:0] slot;
    } t_entry;

    typedef struct packed {
        logic [11:0] entry_index;
        logic        is_new;
        logic        full_res;
        logic [63:0] key_low;
        logic [23:0] key_high;
        logic [12:0] parent;
        logic [7:0]  move_code;
        logic [12:0] entry_count;
    } t_result;

endpackage

FILE: src/fnv_hash_set_insert.sv
// ----------------------------------------------------------------------------
// fnv_hash_set_insert: visited-state set with FNV-1a hash and linear probing
// Insert hashes the key one byte per cycle through a single 32-bit multiplier,
// then walks the slot table until it finds a live equal key, a dead slot, or runs out of slots.
// Read returns one stored entry; clear empties the set by zeroing the count.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                     payload
//  -------   ---------  ----------------------------  ---------------------------
//  in        sink       i_in_valid / o_in_stall       mode, key, parent, move, index
//  out       source     o_out_valid / i_out_stall     index, flags, entry, count
//  cfg       sink       i_cfg_valid / o_cfg_ready     entry_limit
//
//  Insert: KEY_BYTES multiply rounds, then for each slot probed a slot read,
//    an entry read and a compare. Read passes S_RD1 and S_RD2; clear and
//    no-op go straight to S_DONE. A new item is taken only in S_IDLE.
//  A slot is live only if its entry index is below the count and that entry
//    points back at the slot, so clear takes no sweep.
//  After reset a pass over every slot zeroes the slot table; input is stalled
//    meanwhile, cfg writes are taken at any time.
//  A finished result waits in the output register while the next item runs.
// ----------------------------------------------------------------------------
module fnv_hash_set_insert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [63:0] i_key_low,
    input  logic [23:0] i_key_high,
    input  logic [12:0] i_parent,
    input  logic [7:0]  i_move_code,
    input  logic [11:0] i_read_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [11:0] o_entry_index,
    output logic        o_is_new,
    output logic        o_full_res,
    output logic [63:0] o_out_key_low,
    output logic [23:0] o_out_key_high,
    output logic [12:0] o_out_parent,
    output logic [7:0]  o_out_move,
    output logic [12:0] o_entry_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_entry_limit
);
    import fhs_pkg::*;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_SLOT,
        S_ENT,
        S_CMP,
        S_RD1,
        S_RD2,
        S_DONE
    } t_state;

    t_state                r_state;
    t_mode                 r_mode;
    logic [KEY_W-1:0]      r_key;
    logic [KEY_W-1:0]      r_hkey;
    logic [31:0]           r_hash;
    logic [RND_BITS-1:0]   r_round;
    logic [SLOT_BITS-1:0]  r_slot;
    logic [SLOT_BITS-1:0]  r_probe;
    logic [12:0]           r_parent;
    logic [7:0]            r_move;
    logic [11:0]           r_read_idx;
    logic [CNT_BITS-1:0]   r_count;
    logic [12:0]           r_limit;
    t_result               r_res;

    logic [ENT_BITS-1:0]   slot_mem [SLOTS];
    t_entry                ent_mem  [ENTRIES];
    logic [ENT_BITS-1:0]   r_slot_q;
    t_entry                r_ent_q;

    logic [31:0]           n_hash;
    t_result               n_res;
    logic                  in_xfer;
    logic                  out_free;
    logic [CNT_BITS-1:0]   eff_limit;
    logic                  ent_live;
    logic                  key_eq;
    logic                  wr_new;
    logic                  slot_we;
    logic [ENT_BITS-1:0]   slot_wdata;
    logic [ENT_BITS-1:0]   ent_raddr;
    logic                  rd_in_range;
    t_entry                new_ent;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !o_out_valid || !i_out_stall;

    assign n_hash    = (r_hash ^ {24'b0, r_hkey[7:0]}) * FNV_MUL;
    assign eff_limit = (32'(r_limit) > ENTRIES) ? CNT_BITS'(ENTRIES) : CNT_BITS'(r_limit);

    assign ent_live = ({1'b0, r_slot_q} < r_count) && (r_ent_q.slot == r_slot);
    assign key_eq   = (r_ent_q.key_low == r_key[63:0]) && (r_ent_q.key_high == r_key[87:64]);
    assign wr_new   = (r_state == S_CMP) && !ent_live && (r_count < eff_limit);

    assign slot_we    = (r_state == S_INIT) || wr_new;
    assign slot_wdata = (r_state == S_INIT) ? '0 : r_count[ENT_BITS-1:0];

    assign ent_raddr   = (r_mode == MODE_READ) ? ENT_BITS'(r_read_idx) : r_slot_q;
    assign rd_in_range = (32'(r_read_idx) < ENTRIES);

    assign new_ent.key_low   = r_key[63:0];
    assign new_ent.key_high  = r_key[87:64];
    assign new_ent.parent    = r_parent;
    assign new_ent.move_code = r_move;
    assign new_ent.slot      = r_slot;

    // no-op reports the count, every other mode starts from an all-zero result
    always_comb begin
        n_res = '0;
        if (t_mode'(i_mode) == MODE_NOP) begin
            n_res.entry_count = 13'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[r_slot] <= slot_wdata;
        end
        r_slot_q <= slot_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (wr_new) begin
            ent_mem[r_count[ENT_BITS-1:0]] <= new_ent;
        end
        r_ent_q <= ent_mem[ent_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_slot      <= '0;
            r_count     <= '0;
            r_limit     <= LIMIT_RESET;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_entry_limit;
            end
            if (o_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                o_out_valid <= 1'b0;
            end

            case (r_state)
                S_INIT: begin
                    r_slot <= r_slot + 1'b1;
                    if (r_slot == SLOT_BITS'(SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        r_mode     <= t_mode'(i_mode);
                        r_key      <= {i_key_high, i_key_low} & KEY_MASK;
                        r_hkey     <= {i_key_high, i_key_low} & KEY_MASK;
                        r_hash     <= FNV_START;
                        r_round    <= '0;
                        r_probe    <= '0;
                        r_parent   <= i_parent;
                        r_move     <= i_move_code;
                        r_read_idx <= i_read_index;
                        r_res      <= n_res;
                        case (t_mode'(i_mode))
                            MODE_INSERT: r_state <= S_HASH;
                            MODE_READ:   r_state <= S_RD1;
                            MODE_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_HASH: begin
                    r_hash  <= n_hash;
                    r_hkey  <= r_hkey >> 8;
                    r_round <= r_round + 1'b1;
                    if (r_round == RND_BITS'(KEY_BYTES - 1)) begin
                        r_slot  <= n_hash[SLOT_BITS-1:0];
                        r_state <= S_SLOT;
                    end
                end
                S_SLOT: begin
                    r_state <= S_ENT;
                end
                S_ENT: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_state <= S_DONE;
                    if (!ent_live) begin
                        if (wr_new) begin
                            r_count           <= r_count + 1'b1;
                            r_res.entry_index <= 12'(r_count);
                            r_res.is_new      <= 1'b1;
                            r_res.entry_count <= 13'(r_count + 1'b1);
                        end else begin
                            r_res.full_res    <= 1'b1;
                            r_res.entry_count <= 13'(r_count);
                        end
                    end else if (key_eq) begin
                        r_res.entry_index <= 12'(r_slot_q);
                        r_res.entry_count <= 13'(r_count);
                    end else if (r_probe == SLOT_BITS'(SLOTS - 1)) begin
                        r_res.full_res    <= 1'b1;
                        r_res.entry_count <= 13'(r_count);
                    end else begin
                        r_slot  <= r_slot + 1'b1;
                        r_probe <= r_probe + 1'b1;
                        r_state <= S_SLOT;
                    end
                end
                S_RD1: begin
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_res.entry_index <= r_read_idx;
                    r_res.entry_count <= 13'(r_count);
                    if (rd_in_range) begin
                        r_res.key_low   <= r_ent_q.key_low;
                        r_res.key_high  <= r_ent_q.key_high;
                        r_res.parent    <= r_ent_q.parent;
                        r_res.move_code <= r_ent_q.move_code;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        o_out_valid    <= 1'b1;
                        o_entry_index  <= r_res.entry_index;
                        o_is_new       <= r_res.is_new;
                        o_full_res     <= r_res.full_res;
                        o_out_key_low  <= r_res.key_low;
                        o_out_key_high <= r_res.key_high;
                        o_out_parent   <= r_res.parent;
                        o_out_move     <= r_res.move_code;
                        o_entry_count  <= r_res.entry_count;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= ENTRIES)
        else $error("entry count above capacity");

    a_new_xor_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_is_new && o_full_res))
        else $error("result both new and full");

    a_new_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_new) |-> (o_entry_count == 13'(o_entry_index) + 13'd1))
        else $error("new entry index does not match count");

    a_init_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !o_out_valid)
        else $error("result during slot table init");

    a_append_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_new |=> (r_count == $past(r_count) + 1'b1))
        else $error("append did not advance count");

endmodule
